FILE: rtl/cb32_pkg.sv
// ----------------------------------------------------------------------------
// cb32_pkg
// Shared sizes, codes and types of the base32 key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cb32_pkg;

    localparam int BLOB_BYTES = 76;
    localparam int DIGITS     = (BLOB_BYTES * 8 + 4) / 5;
    localparam int PAD_BITS   = DIGITS * 5 - BLOB_BYTES * 8;
    localparam int FIRST_BITS = 5 - PAD_BITS;
    localparam int DIGIT_W    = $clog2(DIGITS + 1);
    localparam logic [4:0] FIRST_MASK = 5'((1 << FIRST_BITS) - 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_DIGIT   = 2'd0;
    localparam logic [1:0] OP_SKIP    = 2'd1;
    localparam logic [1:0] OP_ILLEGAL = 2'd2;
    localparam logic [1:0] OP_TERM    = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ILLEGAL     = 3'd1;
    localparam logic [2:0] ST_TOO_MANY    = 3'd2;
    localparam logic [2:0] ST_WRONG_COUNT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] val;
        logic       eoi;
    } op_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/crockford_base32_key_decoder_unit.sv
// ----------------------------------------------------------------------------
// crockford_base32_key_decoder_unit
// Streaming decoder of base32 key strings into blob bytes and a status.
// ----------------------------------------------------------------------------
// Takes one key byte per cycle unless stalled; a zero byte ends the key and
// yields one status transfer (tuser high). Data bytes go out most significant
// first, each as soon as eight bits are ready. A held prefix byte that is not
// a prefix is queued as its own operation via the classifier's single write
// port. The decoder retires one queued operation and the output side one
// transfer per cycle, each unless stalled; tlast marks the final transfer
// caused by an input byte. Drop the data bytes unless the status is zero.
`default_nettype none

module crockford_base32_key_decoder_unit
    import cb32_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] key_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [10:8] status
    output logic             m_axis_tuser,   // [0] is_status
    output logic             m_axis_tlast
);

    logic push;
    op_t  push_op;
    logic q_full;
    logic pop;
    op_t  pop_op;
    logic q_empty;
    res_t out_res;

    cb32_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .push     (push),
        .push_op  (push_op),
        .q_full   (q_full)
    );

    cb32_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (q_empty)
    );

    cb32_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_op      (pop_op),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {5'd0, out_res.status, out_res.data_byte};
    assign m_axis_tuser = out_res.is_status;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: rtl/cb32_fifo.sv
// ----------------------------------------------------------------------------
// cb32_fifo
// Short operation queue between the front classifier and the back decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_fifo
    import cb32_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    output logic      full,
    input  wire logic pop,
    output op_t       pop_op,
    output logic      empty
);

    op_t              slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg;
    logic [Q_CW-1:0]  count_next;

    assign full   = (count_reg == Q_CW'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cb32_front.sv
// ----------------------------------------------------------------------------
// cb32_front
// Accepts key bytes, tracks the optional prefix and classifies each byte
// into a decode operation for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_front
    import cb32_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    output logic            push,
    output op_t             push_op,
    input  wire logic       q_full
);

    localparam logic [1:0] P_START = 2'd0;
    localparam logic [1:0] P_S     = 2'd1;
    localparam logic [1:0] P_S6    = 2'd2;
    localparam logic [1:0] P_BODY  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_FOUR  = 8'h34;

    localparam logic [4:0] VAL_S   = 5'd25;
    localparam logic [4:0] VAL_SIX = 5'd6;

    // {ok, value}
    function automatic logic [5:0] digit_lookup(input logic [7:0] c);
        logic [7:0] u;
        logic [5:0] r;
        u = c;
        r = '0;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            u = c - 8'h20;
        end
        if (u >= 8'h30 && u <= 8'h39)
        begin
            r = {1'b1, 5'(u - 8'h30)};
        end
        else if (u >= 8'h41 && u <= 8'h48)
        begin
            r = {1'b1, 5'(u - 8'h41 + 8'd10)};
        end
        else if (u == 8'h49 || u == 8'h4C)
        begin
            r = {1'b1, 5'd1};
        end
        else if (u == 8'h4A || u == 8'h4B)
        begin
            r = {1'b1, 5'(u - 8'h4A + 8'd18)};
        end
        else if (u == 8'h4D || u == 8'h4E)
        begin
            r = {1'b1, 5'(u - 8'h4D + 8'd20)};
        end
        else if (u == 8'h4F)
        begin
            r = {1'b1, 5'd0};
        end
        else if (u >= 8'h50 && u <= 8'h54)
        begin
            r = {1'b1, 5'(u - 8'h50 + 8'd22)};
        end
        else if (u >= 8'h56 && u <= 8'h5A)
        begin
            r = {1'b1, 5'(u - 8'h56 + 8'd27)};
        end
        return r;
    endfunction

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       left_valid_reg;
    logic       six_pend_reg;
    op_t        cur_hold_reg;

    logic       accept;
    logic       has_ops;
    logic       extra_one;
    logic       extra_two;
    logic [5:0] lookup;
    op_t        cur_op;
    op_t        first_op;
    op_t        s_op;
    op_t        six_op;

    assign in_ready = !left_valid_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign lookup   = digit_lookup(in_char);
    assign s_op     = '{kind: OP_DIGIT, val: VAL_S, eoi: 1'b0};
    assign six_op   = '{kind: OP_DIGIT, val: VAL_SIX, eoi: 1'b0};

    always_comb
    begin
        cur_op     = '{kind: OP_ILLEGAL, val: 5'd0, eoi: 1'b1};
        if (in_char == CH_NUL)
        begin
            cur_op.kind = OP_TERM;
        end
        else if (in_char == CH_DASH || in_char == CH_SPACE
                 || in_char == CH_TAB || in_char == CH_UNDER)
        begin
            cur_op.kind = OP_SKIP;
        end
        else if (lookup[5])
        begin
            cur_op.kind = OP_DIGIT;
            cur_op.val  = lookup[4:0];
        end
    end

    always_comb
    begin
        phase_next = P_BODY;
        has_ops    = 1'b1;
        extra_one  = 1'b0;
        extra_two  = 1'b0;
        first_op   = cur_op;
        unique case (phase_reg)
            P_START:
            begin
                if (in_char == CH_S || in_char == CH_S_LO)
                begin
                    phase_next = P_S;
                    has_ops    = 1'b0;
                end
            end
            P_S:
            begin
                if (in_char == CH_SIX)
                begin
                    phase_next = P_S6;
                    has_ops    = 1'b0;
                end
                else
                begin
                    first_op  = s_op;
                    extra_one = 1'b1;
                end
            end
            P_S6:
            begin
                if (in_char == CH_FOUR)
                begin
                    has_ops = 1'b0;
                end
                else
                begin
                    first_op  = s_op;
                    extra_two = 1'b1;
                end
            end
            P_BODY:
            begin
            end
        endcase
        if (has_ops && in_char == CH_NUL)
        begin
            phase_next = P_START;
        end
    end

    always_comb
    begin
        push    = 1'b0;
        push_op = first_op;
        if (left_valid_reg)
        begin
            push    = !q_full;
            push_op = six_pend_reg ? six_op : cur_hold_reg;
        end
        else if (accept && has_ops)
        begin
            push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_START;
            left_valid_reg <= 1'b0;
            six_pend_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                if (extra_one || extra_two)
                begin
                    left_valid_reg <= 1'b1;
                    six_pend_reg   <= extra_two;
                end
            end
            else if (left_valid_reg && !q_full)
            begin
                if (six_pend_reg)
                begin
                    six_pend_reg <= 1'b0;
                end
                else
                begin
                    left_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_hold_reg <= cur_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cb32_back.sv
// ----------------------------------------------------------------------------
// cb32_back
// Runs decode operations: packs 5-bit digits into bytes, tracks errors and
// digit count, and issues data bytes and the final status.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_back
    import cb32_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire op_t  q_op,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic [DIGIT_W-1:0] total_reg;
    logic [DIGIT_W-1:0] total_next;
    logic [6:0]         bits_reg;
    logic [6:0]         bits_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         cnt_next;
    logic               fdo_reg;
    logic               fdo_next;
    logic [2:0]         err_reg;
    logic [2:0]         err_next;

    logic               h_valid_reg;
    logic               h_closed_reg;
    res_t               h_res_reg;
    logic               o_valid_reg;
    res_t               o_res_reg;

    logic               new_r;
    res_t               r;
    res_t               h_out;
    logic [11:0]        acc;
    logic [3:0]         acc_cnt;
    logic [3:0]         sh;
    logic               o_free;
    logic               op_go;
    logic               h_move;

    assign acc     = {bits_reg, q_op.val};
    assign acc_cnt = 4'(cnt_reg) + 4'd5;
    assign sh      = acc_cnt - 4'd8;

    always_comb
    begin
        new_r      = 1'b0;
        r          = '0;
        total_next = total_reg;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        fdo_next   = fdo_reg;
        err_next   = err_reg;
        unique case (q_op.kind)
            OP_DIGIT:
            begin
                if (err_reg == ST_OK)
                begin
                    if (total_reg >= DIGIT_W'(DIGITS))
                    begin
                        err_next = ST_TOO_MANY;
                    end
                    else
                    begin
                        total_next = total_reg + 1'b1;
                        if (total_reg == '0)
                        begin
                            fdo_next  = |(q_op.val >> FIRST_BITS);
                            bits_next = 7'(q_op.val & FIRST_MASK);
                            cnt_next  = 3'(FIRST_BITS);
                        end
                        else if (acc_cnt >= 4'd8)
                        begin
                            new_r       = 1'b1;
                            r.data_byte = 8'(acc >> sh);
                            cnt_next    = 3'(sh);
                            bits_next   = 7'(acc & ((12'd1 << sh) - 12'd1));
                        end
                        else
                        begin
                            bits_next = acc[6:0];
                            cnt_next  = 3'(acc_cnt);
                        end
                    end
                end
            end
            OP_SKIP:
            begin
            end
            OP_ILLEGAL:
            begin
                if (err_reg == ST_OK)
                begin
                    err_next = ST_ILLEGAL;
                end
            end
            OP_TERM:
            begin
                new_r       = 1'b1;
                r.is_status = 1'b1;
                priority if (err_reg != ST_OK)
                begin
                    r.status = err_reg;
                end
                else if (total_reg != DIGIT_W'(DIGITS))
                begin
                    r.status = ST_WRONG_COUNT;
                end
                else if (fdo_reg)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    r.status = ST_OK;
                end
                total_next = '0;
                bits_next  = '0;
                cnt_next   = '0;
                fdo_next   = 1'b0;
                err_next   = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        h_out      = h_res_reg;
        h_out.last = h_closed_reg;
    end

    assign o_free = !o_valid_reg || out_ready;
    assign op_go  = !q_empty && (!(new_r && h_valid_reg) || o_free);
    assign h_move = h_valid_reg && o_free && (h_closed_reg || (op_go && new_r));
    assign pop    = op_go;

    assign out_valid = o_valid_reg;
    assign out_res   = o_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            bits_reg     <= '0;
            cnt_reg      <= '0;
            fdo_reg      <= 1'b0;
            err_reg      <= ST_OK;
            h_valid_reg  <= 1'b0;
            h_closed_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (op_go)
            begin
                total_reg <= total_next;
                bits_reg  <= bits_next;
                cnt_reg   <= cnt_next;
                fdo_reg   <= fdo_next;
                err_reg   <= err_next;
            end

            if (op_go && new_r)
            begin
                h_valid_reg  <= 1'b1;
                h_closed_reg <= q_op.eoi;
            end
            else if (h_move)
            begin
                h_valid_reg <= 1'b0;
            end
            else if (op_go && q_op.eoi && h_valid_reg)
            begin
                h_closed_reg <= 1'b1;
            end

            if (h_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_go && new_r)
        begin
            h_res_reg <= r;
        end
        if (h_move)
        begin
            o_res_reg <= h_out;
        end
    end

endmodule

`default_nettype wire
